@@ sv/quaternion_point_rotation_core_defines.svh @@
// Assertion macros for the quaternion point rotation core.
// Used by the checker; expects signals named clock and reset in scope.
`ifndef QUATERNION_POINT_ROTATION_CORE_DEFINES_SVH
`define QUATERNION_POINT_ROTATION_CORE_DEFINES_SVH

// Implication in the same cycle, disabled during reset
`define QPR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles, disabled during reset
`define QPR_ASSERT_DLY(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

@@ sv/qpr_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table.
// No dependencies.
package qpr_pkg;

   // register stages on the axis path and from accept to result
   localparam int AXIS_LAT = 70;
   localparam int LATENCY  = 79;

   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   // unit axis in Q2.30 plus the zero axis flag
   typedef struct packed {
      logic               zero;
      logic signed [31:0] ux;
      logic signed [31:0] uy;
      logic signed [31:0] uz;
   } unit_beat_type;

   // atan(2^-idx) in Q2.30, truncated
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000007;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

@@ sv/qpr_delay.sv @@
// Fixed-depth shift line for pipeline payload alignment.
// No dependencies.
module qpr_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   // advance every tap each cycle
   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

@@ sv/qpr_mulq30.sv @@
// Two-stage signed multiply, round(a*b/2^30) half away from zero.
// Splits a into two partial products; no dependencies.
module qpr_mulq30 #(
   parameter int AW = 34,
   parameter int BW = 34,
   parameter int RW = 34
) (
   input  logic                 clock,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [RW-1:0] p
);
   localparam int LOW = 24;
   localparam int HW  = AW - LOW;
   localparam int FW  = AW + BW;

   logic [AW-1:0] ua;
   logic [BW-1:0] ub;
   logic [LOW+BW-1:0] lo_ff;
   logic [HW+BW-1:0]  hi_ff;
   logic              neg_ff;
   logic [FW-1:0]     full;
   logic signed [RW-1:0] mag;
   logic signed [RW-1:0] p_ff;

   assign ua = a[AW-1] ? AW'(-a) : AW'(a);
   assign ub = b[BW-1] ? BW'(-b) : BW'(b);

   // stage one: partial products of the magnitudes
   always_ff @(posedge clock) begin
      lo_ff  <= ua[LOW-1:0] * ub;
      hi_ff  <= ua[AW-1:LOW] * ub;
      neg_ff <= a[AW-1] ^ b[BW-1];
   end

   // stage two: combine, round, apply sign
   always_comb begin
      full = {hi_ff, {LOW{1'b0}}} + FW'(lo_ff) + FW'(32'd536870912);
      mag  = RW'(full[FW-1:30]);
   end

   always_ff @(posedge clock) begin
      p_ff <= neg_ff ? -mag : mag;
   end

   assign p = p_ff;
endmodule

@@ sv/qpr_axis.sv @@
// Axis normalizer: magnitude scaling, pipelined square root and dividers.
// Depends on qpr_pkg.
module qpr_axis
   import qpr_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] axis_x,
   input  logic signed [31:0] axis_y,
   input  logic signed [31:0] axis_z,
   output unit_beat_type      unit
);
   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 31;

   typedef struct packed {
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][31:0] am;
   } sq_carry_type;

   typedef struct packed {
      logic             zero;
      logic [2:0]       neg;
      logic [31:0]      len;
      logic [2:0][61:0] num;
   } div_carry_type;

   function automatic logic [4:0] norm_shift(input logic [31:0] v);
      logic [4:0] pos;
      pos = '0;
      for (int i = 0; i < 31; i++) begin
         if (v[i]) pos = 5'(i);
      end
      return v[31] ? 5'd0 : 5'(5'd30 - pos);
   endfunction

   logic signed [31:0] ax [3];
   logic [2:0][31:0] am_in, am1_ff, am2_ff, am3_ff;
   logic [2:0][63:0] sq4_ff;
   logic [2:0][31:0] am4_ff;
   logic [31:0] mx_in, mx1_ff;
   logic [2:0]  neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic        zero2_ff, zero3_ff, zero4_ff;
   logic [4:0]  sh2_ff;

   logic [63:0]  rad_ff  [SQ_STEPS];
   logic [33:0]  rem_ff  [SQ_STEPS+1];
   logic [31:0]  root_ff [SQ_STEPS+1];
   sq_carry_type sqc_ff  [SQ_STEPS+1];

   logic [2:0][61:0] num_in;
   div_carry_type    dc_ff [DIV_STEPS+1];
   logic [30:0]      quo [3];
   unit_beat_type    unit_in, unit_ff;

   assign ax[0] = axis_x;
   assign ax[1] = axis_y;
   assign ax[2] = axis_z;

   // stage 1: magnitudes and largest magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         am_in[i] = ax[i][31] ? 32'(-ax[i]) : 32'(ax[i]);
      end
      mx_in = am_in[0];
      if (am_in[1] > mx_in) mx_in = am_in[1];
      if (am_in[2] > mx_in) mx_in = am_in[2];
   end

   always_ff @(posedge clock) begin
      am1_ff  <= am_in;
      mx1_ff  <= mx_in;
      neg1_ff <= {ax[2][31], ax[1][31], ax[0][31]};
   end

   // stage 2: find the normalizing shift
   always_ff @(posedge clock) begin
      am2_ff   <= am1_ff;
      neg2_ff  <= neg1_ff;
      zero2_ff <= (mx1_ff == 32'd0);
      sh2_ff   <= norm_shift(mx1_ff);
   end

   // stage 3: shift so the largest magnitude lands in [2^30, 2^31]
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         am3_ff[i] <= am2_ff[i] << sh2_ff;
      end
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
   end

   // stage 4: squares
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq4_ff[i] <= am3_ff[i] * am3_ff[i];
      end
      am4_ff   <= am3_ff;
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;
   end

   // stage 5: sum of squares enters the root pipeline
   always_ff @(posedge clock) begin
      rad_ff[0]  <= sq4_ff[0] + sq4_ff[1] + sq4_ff[2];
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      sqc_ff[0]  <= '{zero: zero4_ff, neg: neg4_ff, am: am4_ff};
   end

   // floor square root, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam int J = SQ_STEPS - 1 - k;
      logic [35:0] rsh;
      logic [35:0] trial;
      logic        ge;

      always_comb begin
         rsh   = {rem_ff[k], rad_ff[k][2*J+1 -: 2]};
         trial = {2'b00, root_ff[k], 2'b01};
         ge    = (rsh >= trial);
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? 34'(rsh - trial) : 34'(rsh);
         root_ff[k+1] <= {root_ff[k][30:0], ge};
         sqc_ff[k+1]  <= sqc_ff[k];
      end

      if (k < SQ_STEPS - 1) begin : g_rad
         always_ff @(posedge clock) begin
            rad_ff[k+1] <= rad_ff[k];
         end
      end
   end

   // dividend with half the divisor added for rounding
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {sqc_ff[SQ_STEPS].am[i], 30'd0} + 62'(root_ff[SQ_STEPS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      dc_ff[0] <= '{zero: sqc_ff[SQ_STEPS].zero, neg: sqc_ff[SQ_STEPS].neg,
                    len: root_ff[SQ_STEPS], num: num_in};
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dcarry
      always_ff @(posedge clock) begin
         dc_ff[j+1] <= dc_ff[j];
      end
   end

   // restoring dividers, one quotient bit per stage, one lane per component
   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [31:0] drem_ff [DIV_STEPS];
      logic [30:0] quo_ff  [DIV_STEPS+1];

      always_ff @(posedge clock) begin
         drem_ff[0] <= 32'(num_in[l][61:31]);
         quo_ff[0]  <= '0;
      end

      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
         logic [32:0] dsh;
         logic        ge;

         always_comb begin
            dsh = {drem_ff[j], dc_ff[j].num[l][DIV_STEPS-1-j]};
            ge  = (dsh >= {1'b0, dc_ff[j].len});
         end

         always_ff @(posedge clock) begin
            quo_ff[j+1] <= {quo_ff[j][29:0], ge};
         end

         if (j < DIV_STEPS - 1) begin : g_rem
            always_ff @(posedge clock) begin
               drem_ff[j+1] <= ge ? 32'(dsh - {1'b0, dc_ff[j].len}) : 32'(dsh);
            end
         end
      end

      assign quo[l] = quo_ff[DIV_STEPS];
   end

   // restore the component signs
   always_comb begin
      unit_in.zero = dc_ff[DIV_STEPS].zero;
      unit_in.ux   = dc_ff[DIV_STEPS].neg[0] ? -$signed({1'b0, quo[0]}) : $signed({1'b0, quo[0]});
      unit_in.uy   = dc_ff[DIV_STEPS].neg[1] ? -$signed({1'b0, quo[1]}) : $signed({1'b0, quo[1]});
      unit_in.uz   = dc_ff[DIV_STEPS].neg[2] ? -$signed({1'b0, quo[2]}) : $signed({1'b0, quo[2]});
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
   end

   assign unit = unit_ff;
endmodule

@@ sv/qpr_cordic.sv @@
// Pipelined rotation-mode CORDIC: cosine and sine of half the angle, Q2.30.
// Depends on qpr_pkg.
module qpr_cordic
   import qpr_pkg::*;
#(
   parameter int STEPS = 24
) (
   input  logic               clock,
   input  logic signed [31:0] angle,
   output logic signed [33:0] cos_q30,
   output logic signed [33:0] sin_q30
);
   logic signed [33:0] x_ff [STEPS+1];
   logic signed [33:0] y_ff [STEPS+1];
   logic signed [34:0] z_ff [STEPS+1];
   logic               flip_ff [STEPS+1];
   logic signed [34:0] h, z_in;
   logic               flip_in;
   logic signed [33:0] cos_ff, sin_ff;

   // double the angle to Q2.30 and fold it into [-pi/2, pi/2]
   always_comb begin
      h       = 35'(angle) <<< 1;
      z_in    = h;
      flip_in = 1'b0;
      if (h > HALF_PI_Q30) begin
         z_in    = h - PI_Q30;
         flip_in = 1'b1;
      end else if (h < -HALF_PI_Q30) begin
         z_in    = h + PI_Q30;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= GAIN_Q30;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [33:0] dx, dy;
      logic signed [34:0] at;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         at = $signed({3'b000, atan_q30(5'(i))});
      end

      always_ff @(posedge clock) begin
         if (!z_ff[i][34]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - at;
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + at;
         end
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   // undo the fold by negating both terms
   always_ff @(posedge clock) begin
      cos_ff <= flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      sin_ff <= flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;
endmodule

@@ sv/quaternion_point_rotation_core.sv @@
// Quaternion point rotation core: rotates a Q16.16 point by an angle about
// an axis through a pivot. Depends on qpr_pkg, qpr_axis, qpr_cordic,
// qpr_mulq30 and qpr_delay.
//
// Input: a beat is taken at each rising edge with start high and busy low.
// busy is high only during reset, so one beat can enter every cycle.
// Output: each result appears on rsp_* for one cycle with rsp_valid high,
// once its beat has passed through every pipeline register; results keep input order.
// Throughput: one beat per cycle. The latency is set by the axis path:
// a 32-stage square root and 31-stage dividers, one bit per stage,
// followed by two rounds of pipelined quaternion products.
// A zero axis gives rsp_zero_axis high and zero coordinates.
// Reset clears the valid line; beats in flight are dropped.
// The receiver cannot stall the result channel, so nothing backs up.
module quaternion_point_rotation_core
   import qpr_pkg::*;
#(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_pivot_x,
   input  logic signed [31:0] req_pivot_y,
   input  logic signed [31:0] req_pivot_z,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_rotated_x,
   output logic signed [31:0] rsp_rotated_y,
   output logic signed [31:0] rsp_rotated_z,
   output logic               rsp_zero_axis
);
   localparam int CORDIC_PAD = AXIS_LAT - CORDIC_STEPS - 2;
   localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
   localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

   logic               accept;
   logic [LATENCY-1:0] valid_ff;
   unit_beat_type      unit;
   logic signed [33:0] cos_c, sin_c, x70, y70;
   logic signed [31:0] ucomp [3];
   logic signed [31:0] point [3];
   logic signed [31:0] pivot [3];
   logic signed [31:0] piv78 [3];
   logic signed [41:0] pv_in [3];
   logic signed [41:0] pv1_ff [3];
   logic signed [41:0] pv72 [3];
   logic signed [33:0] q72 [4];
   logic signed [33:0] q75 [4];
   logic signed [42:0] m1 [4][3];
   logic signed [44:0] t_in [4];
   logic signed [44:0] t_ff [4];
   logic signed [45:0] m2 [4][3];
   logic signed [47:0] d_in [3];
   logic signed [47:0] d_ff [3];
   logic               zero78;
   logic signed [48:0] rnd [3];
   logic signed [41:0] sum [3];
   logic signed [31:0] sat [3];
   logic signed [31:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic               zero_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   // valid travels beside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LATENCY-2:0], accept};
      end
   end

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;
   assign pivot[0] = req_pivot_x;
   assign pivot[1] = req_pivot_y;
   assign pivot[2] = req_pivot_z;

   qpr_axis u_axis (
      .clock  (clock),
      .axis_x (req_axis_x),
      .axis_y (req_axis_y),
      .axis_z (req_axis_z),
      .unit   (unit)
   );

   qpr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .angle   (req_angle),
      .cos_q30 (cos_c),
      .sin_q30 (sin_c)
   );

   // align cosine and sine with the unit axis
   qpr_delay #(.WIDTH(34), .DEPTH(CORDIC_PAD)) u_cos_pad (
      .clock (clock), .din (cos_c), .dout (x70));
   qpr_delay #(.WIDTH(34), .DEPTH(CORDIC_PAD)) u_sin_pad (
      .clock (clock), .din (sin_c), .dout (y70));

   assign ucomp[0] = unit.ux;
   assign ucomp[1] = unit.uy;
   assign ucomp[2] = unit.uz;

   // quaternion: scalar term from cosine, vector from sine times unit axis
   qpr_delay #(.WIDTH(34), .DEPTH(2)) u_q0_dly (
      .clock (clock), .din (x70), .dout (q72[0]));

   for (genvar n = 0; n < 3; n++) begin : g_qvec
      qpr_mulq30 #(.AW(34), .BW(32), .RW(34)) u_qmul (
         .clock (clock), .a (y70), .b (ucomp[n]), .p (q72[n+1]));
   end

   // point relative to the pivot, Q.24
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         pv_in[n] = 42'(33'(point[n]) - 33'(pivot[n])) <<< 8;
      end
   end

   always_ff @(posedge clock) begin
      pv1_ff <= pv_in;
   end

   for (genvar n = 0; n < 3; n++) begin : g_pv
      qpr_delay #(.WIDTH(42), .DEPTH(AXIS_LAT + 1)) u_pv_dly (
         .clock (clock), .din (pv1_ff[n]), .dout (pv72[n]));
      qpr_delay #(.WIDTH(32), .DEPTH(LATENCY - 1)) u_piv_dly (
         .clock (clock), .din (pivot[n]), .dout (piv78[n]));
   end

   // first product q * p: every quaternion term times every point term
   for (genvar i = 0; i < 4; i++) begin : g_h1
      for (genvar j = 0; j < 3; j++) begin : g_col
         qpr_mulq30 #(.AW(42), .BW(34), .RW(43)) u_mul (
            .clock (clock), .a (pv72[j]), .b (q72[i]), .p (m1[i][j]));
      end
      qpr_delay #(.WIDTH(34), .DEPTH(3)) u_q_dly (
         .clock (clock), .din (q72[i]), .dout (q75[i]));
   end

   always_comb begin
      t_in[0] = -(45'(m1[1][0]) + 45'(m1[2][1]) + 45'(m1[3][2]));
      t_in[1] = 45'(m1[0][0]) + 45'(m1[2][2]) - 45'(m1[3][1]);
      t_in[2] = 45'(m1[0][1]) - 45'(m1[1][2]) + 45'(m1[3][0]);
      t_in[3] = 45'(m1[0][2]) + 45'(m1[1][1]) - 45'(m1[2][0]);
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

   // second product t * conj(q); term i of output n pairs t[i] with q[i^n]
   for (genvar i = 0; i < 4; i++) begin : g_h2
      for (genvar n = 1; n < 4; n++) begin : g_col
         qpr_mulq30 #(.AW(45), .BW(34), .RW(46)) u_mul (
            .clock (clock), .a (t_ff[i]), .b (q75[i ^ n]), .p (m2[i][n-1]));
      end
   end

   always_comb begin
      d_in[0] = -48'(m2[0][0]) + 48'(m2[1][0]) - 48'(m2[2][0]) + 48'(m2[3][0]);
      d_in[1] = -48'(m2[0][1]) + 48'(m2[1][1]) + 48'(m2[2][1]) - 48'(m2[3][1]);
      d_in[2] = -48'(m2[0][2]) - 48'(m2[1][2]) + 48'(m2[2][2]) + 48'(m2[3][2]);
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   qpr_delay #(.WIDTH(1), .DEPTH(LATENCY - 1 - AXIS_LAT)) u_zero_dly (
      .clock (clock), .din (unit.zero), .dout (zero78));

   // round back to Q16.16, add the pivot, saturate
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         rnd[n] = (49'(d_ff[n]) + 49'sd128) >>> 8;
         sum[n] = 42'(rnd[n]) + 42'(piv78[n]);
         if (zero78) begin
            sat[n] = '0;
         end else if (sum[n] > SAT_MAX) begin
            sat[n] = 32'(SAT_MAX);
         end else if (sum[n] < SAT_MIN) begin
            sat[n] = 32'(SAT_MIN);
         end else begin
            sat[n] = 32'(sum[n]);
         end
      end
   end

   always_ff @(posedge clock) begin
      rot_x_ff <= sat[0];
      rot_y_ff <= sat[1];
      rot_z_ff <= sat[2];
      zero_ff  <= zero78;
   end

   assign rsp_valid     = valid_ff[LATENCY-1];
   assign rsp_rotated_x = rot_x_ff;
   assign rsp_rotated_y = rot_y_ff;
   assign rsp_rotated_z = rot_z_ff;
   assign rsp_zero_axis = zero_ff;
endmodule

@@ sv/qpr_checker.sv @@
// Port-level checker for the rotation core and its bind statement.
// Depends on qpr_pkg and quaternion_point_rotation_core_defines.svh.
`include "quaternion_point_rotation_core_defines.svh"

module qpr_checker
   import qpr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_axis_x,
   input logic signed [31:0] req_axis_y,
   input logic signed [31:0] req_axis_z,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_rotated_x,
   input logic signed [31:0] rsp_rotated_y,
   input logic signed [31:0] rsp_rotated_z,
   input logic               rsp_zero_axis
);
   logic beat_taken;
   logic axis_zero;
   logic coords_zero;

   assign beat_taken  = start && !busy;
   assign axis_zero   = req_axis_x == 32'sd0 && req_axis_y == 32'sd0 && req_axis_z == 32'sd0;
   assign coords_zero = rsp_rotated_x == 32'sd0 && rsp_rotated_y == 32'sd0 &&
                        rsp_rotated_z == 32'sd0;

   // every accepted beat yields a result after the fixed latency
   `QPR_ASSERT_DLY(a_result_due, beat_taken, LATENCY, rsp_valid, "result beat missing")

   // no result without an accepted beat at the matching time
   `QPR_ASSERT_IMP(a_no_phantom, rsp_valid, $past(beat_taken, LATENCY), "unexpected result beat")

   // an all-zero axis is flagged on its result
   `QPR_ASSERT_DLY(a_zero_flag, beat_taken && axis_zero, LATENCY, rsp_valid && rsp_zero_axis, "zero axis not flagged")

   // a flagged result carries zero coordinates
   `QPR_ASSERT_IMP(a_zero_coords, rsp_valid && rsp_zero_axis, coords_zero, "zero axis with nonzero coordinates")
endmodule

bind quaternion_point_rotation_core qpr_checker u_qpr_checker (.*);
